@@ rtl/mccs_pkg.sv @@
// mccs_pkg: shared types and constants of the multi-channel countdown switch
// channel entry layout, result layout, command and report codes
// no dependencies
package mccs_pkg;

	localparam int VALUE_W = 17;
	localparam logic [VALUE_W-1:0] VALUE_MAX = 17'd86400;

	// report period check: floor(x / p) is approximated by (x * RECIP) >> RECIP_SHIFT
	localparam int RECIP_SHIFT = 29;
	localparam int RECIP_W = RECIP_SHIFT + 1;

	// hardware channel limit and config field widths
	localparam int HW_CHANNELS = 8;
	localparam int CH_W = 3;
	localparam int CNT_W = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 4;

	// command modes
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_SWITCH = 2'd1;
	localparam logic [1:0] MODE_COUNTDOWN = 2'd2;
	localparam logic [1:0] MODE_ANNOUNCE = 2'd3;

	// report kinds
	localparam logic KIND_SWITCH = 1'b0;
	localparam logic KIND_COUNT = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_DOWN_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_IN_USE = 1'd1;

	typedef struct packed {
		logic on;
		logic active;
		logic [VALUE_W-1:0] seconds;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic kind;
		logic [CH_W-1:0] channel;
		logic [VALUE_W-1:0] value;
	} result_t;

endpackage

@@ rtl/mccs_ram.sv @@
// mccs_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module mccs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/multi_channel_countdown_switch.sv @@
// multi_channel_countdown_switch: top level, channel sequencer around the state ram
// depends on mccs_pkg and mccs_ram
//
//  channel   handshake                  payload
//  command   start / busy               mode, channel, value
//  result    result_strobe (no stall)   report_kind, report_channel, report_value, last
//  config    cfg_wr_en                  cfg_index, cfg_data
//
// an item is taken when start is high and busy is low; busy stays high until
// its last report has been handed to the output register
// single-channel commands go through read, modify/write, an optional second report and
// the flush; tick and announce walk the channels in use with read, modify/write and,
// where needed, a second report or period check each, then the flush; the single ram port sets the pace
// commands turned away at the door (channel not in use, value out of range, no
// channel in use, tick while disabled) leave busy low; a tick that walks the
// channels but finds nothing to report still takes the full walk
// reset clears control state and the per-entry valid bits, the ram itself is not swept
// each report is shown for one cycle on result_strobe; the receiver cannot stall
module multi_channel_countdown_switch
	import mccs_pkg::*;
#(
	parameter int CHANNELS = 8,
	parameter int REPORT_PERIOD = 30
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            mode,
	input  logic [CH_W-1:0]       channel,
	input  logic [VALUE_W-1:0]    value,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  result_strobe,
	output logic                  report_kind,
	output logic [CH_W-1:0]       report_channel,
	output logic [VALUE_W-1:0]    report_value,
	output logic                  last
);

	// only the first eight channels are reachable through a 3-bit channel field
	localparam int LIVE = (CHANNELS < HW_CHANNELS) ? CHANNELS : HW_CHANNELS;
	localparam int ADDR_W = (LIVE > 1) ? $clog2(LIVE) : 1;
	localparam logic [CNT_W-1:0] LIVE_CNT = CNT_W'(LIVE);

	// reciprocal of the report period and the product widths it needs
	localparam int PER_W = $clog2(REPORT_PERIOD + 1);
	localparam logic [PER_W-1:0] PERIOD = PER_W'(REPORT_PERIOD);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / REPORT_PERIOD);
	localparam int PROD_W = VALUE_W + RECIP_W;
	localparam int QUO_W = PROD_W - RECIP_SHIFT;
	localparam int QP_W = QUO_W + PER_W + 1;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD = 3'd1;   // ram read issued
	localparam logic [2:0] ST_MOD = 3'd2;  // entry back, modify and write
	localparam logic [2:0] ST_CHK = 3'd3;  // report period check after a decrement
	localparam logic [2:0] ST_SEC = 3'd4;  // second report of a channel
	localparam logic [2:0] ST_FIN = 3'd5;  // flush the held report marked last

	// configuration registers
	logic                  count_down_enable_q;
	logic [CNT_W-1:0]      channels_in_use_q;

	// sequencer registers
	logic [2:0]            state_q;
	logic [1:0]            mode_q;
	logic [CH_W-1:0]       idx_q;
	logic [VALUE_W-1:0]    val_q;
	logic [CNT_W-1:0]      n_q;
	result_t               sec_res_q;
	logic [VALUE_W-1:0]    dec_q;
	logic [PROD_W-1:0]     prod_q;

	// one report held back until we know whether it is the last one
	result_t               hold_q;
	logic                  hold_v_q;

	// ram side
	logic [LIVE-1:0]       vld_q;
	logic                  rd_vld_q;
	logic                  ram_rd_en;
	logic [ENTRY_W-1:0]    ram_rd_data;
	logic                  wr_en;
	entry_t                wdata;
	entry_t                rd_entry;
	logic [ADDR_W-1:0]     addr;

	// combinational control
	logic [CNT_W-1:0]      n_live;
	logic                  accept;
	logic                  go;
	logic [CH_W-1:0]       first_idx;
	logic                  gen;
	result_t               gen_res;
	logic                  need_sec;
	logic                  need_chk;
	result_t               sec_res;
	logic [VALUE_W-1:0]    dec_w;
	logic                  walking;
	logic                  more;
	logic [CNT_W-1:0]      idx_next;
	logic [QUO_W-1:0]      quo;
	logic [QP_W-1:0]       qp;
	logic                  divisible;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);
	assign n_live = (channels_in_use_q > LIVE_CNT) ? LIVE_CNT : channels_in_use_q;

	// decide at the door whether the command touches any channel at all
	always_comb begin
		go = 1'b0;
		first_idx = '0;
		case (mode)
			MODE_TICK: begin
				go = count_down_enable_q && (n_live != '0);
			end
			MODE_SWITCH, MODE_COUNTDOWN: begin
				go = ({1'b0, channel} < n_live) && (value <= VALUE_MAX);
				first_idx = channel;
			end
			MODE_ANNOUNCE: begin
				go = (n_live != '0);
			end
			default: begin
				go = 1'b0;
			end
		endcase
	end

	// ram access: read in ST_RD, write back in ST_MOD, same address register
	assign addr = idx_q[ADDR_W-1:0];
	assign ram_rd_en = (state_q == ST_RD);
	assign rd_entry = rd_vld_q ? entry_t'(ram_rd_data) : '0;

	mccs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(LIVE)
	) u_state_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr),
		.wr_data (wdata),
		.rd_en   (ram_rd_en),
		.rd_addr (addr),
		.rd_data (ram_rd_data)
	);

	assign dec_w = rd_entry.seconds - VALUE_W'(1);

	// divisibility of the decremented count: quo is floor(x/p) or one less,
	// so x is a multiple of p exactly when x equals quo*p or quo*p + p
	assign quo = prod_q[PROD_W-1:RECIP_SHIFT];
	assign qp = QP_W'(quo) * QP_W'(PERIOD);
	assign divisible = (QP_W'(dec_q) == qp) || (QP_W'(dec_q) == qp + QP_W'(PERIOD));

	// walk bookkeeping
	assign walking = (mode_q == MODE_TICK) || (mode_q == MODE_ANNOUNCE);
	assign idx_next = CNT_W'(idx_q) + CNT_W'(1);
	assign more = walking && (idx_next < n_q);

	// modify step and report generation
	always_comb begin
		wr_en = 1'b0;
		wdata = rd_entry;
		gen = 1'b0;
		gen_res = '0;
		need_sec = 1'b0;
		need_chk = 1'b0;
		sec_res = '0;
		case (state_q)
			ST_MOD: begin
				case (mode_q)
					MODE_TICK: begin
						if (rd_entry.active) begin
							wr_en = 1'b1;
							if (rd_entry.seconds <= VALUE_W'(1)) begin
								// expiry: toggle, report state then a zero count
								wdata.on = !rd_entry.on;
								wdata.active = 1'b0;
								wdata.seconds = '0;
								gen = 1'b1;
								gen_res = '{KIND_SWITCH, idx_q, VALUE_W'(!rd_entry.on)};
								need_sec = 1'b1;
								sec_res = '{KIND_COUNT, idx_q, '0};
							end else begin
								wdata.seconds = dec_w;
								need_chk = 1'b1;
							end
						end
					end
					MODE_SWITCH: begin
						wr_en = 1'b1;
						wdata.on = (val_q != '0);
						gen = 1'b1;
						gen_res = '{KIND_SWITCH, idx_q, VALUE_W'(val_q != '0)};
						if (count_down_enable_q && rd_entry.active) begin
							wdata.active = 1'b0;
							wdata.seconds = '0;
							need_sec = 1'b1;
							sec_res = '{KIND_COUNT, idx_q, '0};
						end
					end
					MODE_COUNTDOWN: begin
						wr_en = 1'b1;
						wdata.active = (val_q != '0);
						wdata.seconds = val_q;
						gen = 1'b1;
						gen_res = '{KIND_COUNT, idx_q, val_q};
					end
					MODE_ANNOUNCE: begin
						gen = 1'b1;
						gen_res = '{KIND_SWITCH, idx_q, VALUE_W'(rd_entry.on)};
						if (count_down_enable_q) begin
							wr_en = 1'b1;
							wdata.active = 1'b0;
							wdata.seconds = '0;
							need_sec = 1'b1;
							sec_res = '{KIND_COUNT, idx_q, '0};
						end
					end
					default: begin
						wr_en = 1'b0;
					end
				endcase
			end
			ST_CHK: begin
				gen = divisible;
				gen_res = '{KIND_COUNT, idx_q, dec_q};
			end
			ST_SEC: begin
				gen = 1'b1;
				gen_res = sec_res_q;
			end
			default: begin
				gen = 1'b0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_down_enable_q <= 1'b1;
			channels_in_use_q <= CNT_W'(2);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_COUNT_DOWN_ENABLE: count_down_enable_q <= cfg_data[0];
				REG_CHANNELS_IN_USE: channels_in_use_q <= cfg_data;
				default: channels_in_use_q <= channels_in_use_q;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= MODE_TICK;
			idx_q <= '0;
			n_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && go) begin
						state_q <= ST_RD;
						mode_q <= mode;
						idx_q <= first_idx;
						n_q <= n_live;
					end
				end
				ST_RD: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (need_chk) begin
						state_q <= ST_CHK;
					end else if (need_sec) begin
						state_q <= ST_SEC;
					end else if (more) begin
						state_q <= ST_RD;
						idx_q <= idx_next[CH_W-1:0];
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_CHK, ST_SEC: begin
					if (more) begin
						state_q <= ST_RD;
						idx_q <= idx_next[CH_W-1:0];
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= value;
		end
		if (state_q == ST_MOD) begin
			sec_res_q <= sec_res;
			dec_q <= dec_w;
			prod_q <= PROD_W'(dec_w) * PROD_W'(RECIP);
		end
		if (ram_rd_en) begin
			rd_vld_q <= vld_q[addr];
		end
	end

	// valid bits: an entry never written reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[addr] <= 1'b1;
		end
	end

	// output stage: a new report pushes the held one out, the flush marks it last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			result_strobe <= 1'b0;
			last <= 1'b0;
		end else begin
			result_strobe <= 1'b0;
			last <= 1'b0;
			if (gen) begin
				hold_v_q <= 1'b1;
				result_strobe <= hold_v_q;
			end else if (state_q == ST_FIN) begin
				hold_v_q <= 1'b0;
				result_strobe <= hold_v_q;
				last <= hold_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gen) begin
			hold_q <= gen_res;
		end
		if ((gen || (state_q == ST_FIN)) && hold_v_q) begin
			report_kind <= hold_q.kind;
			report_channel <= hold_q.channel;
			report_value <= hold_q.value;
		end
	end

`ifndef SYNTHESIS
	// nothing may still be held back when a new item comes in
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> !hold_v_q)
		else $error("held report left over at item accept");

	// the flush always empties the hold register
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> !hold_v_q)
		else $error("hold register not emptied by flush");

	// last only ever rides on a strobed report
	assert property (@(posedge clk) disable iff (!arst_n)
		last |-> result_strobe)
		else $error("last without result strobe");

	// the channel being worked on is always within the count taken at accept
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ({1'b0, idx_q} < n_q))
		else $error("channel index beyond channels in use");

	// the ram is written only in the modify step
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> $past(state_q) == ST_RD)
		else $error("ram write not preceded by a read");
`endif

endmodule
